// ===== sv/rcpf_pkg.sv =====
// Package for the rounded-corner planar framebuffer.
// Holds the screen geometry, the memory sizes, the command codes and the controller states.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package rcpf_pkg;

    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int CORNER_RADIUS = 12;

    localparam int X_W = 10;
    localparam int Y_W = 9;
    localparam int COLOR_W = 4;
    localparam int PLANE_W = 2;
    localparam int FUNC_W = 3;
    localparam int PIX_W = 4;
    localparam int WORD_W = 32;
    localparam int PIX_PER_WORD = 8;

    localparam int ROW_WORDS   = (SCREEN_WIDTH + PIX_PER_WORD - 1) / PIX_PER_WORD;
    localparam int STORE_WORDS = ROW_WORDS * SCREEN_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_WORDS);

    localparam int RIGHT_EDGE  = SCREEN_WIDTH - CORNER_RADIUS;
    localparam int BOTTOM_EDGE = SCREEN_HEIGHT - CORNER_RADIUS;
    localparam int DIST_W      = $clog2(CORNER_RADIUS + 1);
    localparam int SQ_W        = 2 * DIST_W + 1;
    localparam int RADIUS_SQ   = CORNER_RADIUS * CORNER_RADIUS;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE  = 3'd0,
        FUNC_READ   = 3'd1,
        FUNC_INVERT = 3'd2,
        FUNC_PLANE  = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RMW,
        ST_CLEAR,
        ST_CLEAR_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== sv/rounded_corner_planar_framebuffer.sv =====
// Top level of the rounded-corner planar framebuffer: controller and pixel store memory.
// Depends on rcpf_pkg for geometry, command codes and states.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      func, x, y, color, plane
// result    out        done strobe, one cycle    pixel, plane_byte, changed
//
// A pixel or plane command does the memory read, then the modify and write back.
// The registered result follows in the next cycle, when the next item can already be taken.
// A clear walks every word of the store with one read and one write each cycle.
// After reset the same sweep zeroes the store while busy stays high.
// The result receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module rounded_corner_planar_framebuffer
    import rcpf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [X_W-1:0]     x,
    input  wire logic [Y_W-1:0]     y,
    input  wire logic [COLOR_W-1:0] color,
    input  wire logic [PLANE_W-1:0] plane,
    output logic                    busy,
    output logic                    done,
    output logic [PIX_W-1:0]        pixel,
    output logic [7:0]              plane_byte,
    output logic                    changed
);

    logic [WORD_W-1:0] mem [STORE_WORDS];
    logic [WORD_W-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_we;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               acc_reg, acc_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [X_W-1:0]     x_reg;
    logic [COLOR_W-1:0] color_reg;
    logic [PLANE_W-1:0] plane_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               on_screen_reg;
    logic               blocked_reg;

    logic               done_reg, done_next;
    logic [PIX_W-1:0]   pixel_reg, pixel_next;
    logic [7:0]         plane_byte_reg, plane_byte_next;
    logic               changed_reg, changed_next;

    logic               accept;
    logic               on_screen;
    logic [ADDR_W-1:0]  in_addr;
    logic               left, right, top, bottom;
    logic [X_W-1:0]     dx_full;
    logic [Y_W-1:0]     dy_full;
    logic [DIST_W-1:0]  dx, dy;
    logic [SQ_W-1:0]    dist_sq;
    logic               blocked;

    logic [PIX_W-1:0]   cur_pix;
    logic [PIX_W-1:0]   new_pix;
    logic [WORD_W-1:0]  new_word;
    logic [7:0]         pbyte;
    logic [X_W:0]       col;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign on_screen = ({1'b0, x} < (X_W+1)'(SCREEN_WIDTH)) &&
                       ({1'b0, y} < (Y_W+1)'(SCREEN_HEIGHT));
    assign in_addr   = on_screen ?
                       ADDR_W'(int'(y) * ROW_WORDS + int'(x[X_W-1:3])) : '0;

    assign left    = ({1'b0, x} < (X_W+1)'(CORNER_RADIUS));
    assign right   = ({1'b0, x} >= (X_W+1)'(RIGHT_EDGE));
    assign top     = ({1'b0, y} < (Y_W+1)'(CORNER_RADIUS));
    assign bottom  = ({1'b0, y} >= (Y_W+1)'(BOTTOM_EDGE));
    assign dx_full = left ? (X_W'(CORNER_RADIUS - 1) - x) : (x - X_W'(RIGHT_EDGE));
    assign dy_full = top ? (Y_W'(CORNER_RADIUS - 1) - y) : (y - Y_W'(BOTTOM_EDGE));
    assign dx      = dx_full[DIST_W-1:0];
    assign dy      = dy_full[DIST_W-1:0];
    assign dist_sq = (SQ_W'(dx) * SQ_W'(dx)) + (SQ_W'(dy) * SQ_W'(dy));
    assign blocked = (left || right) && (top || bottom) &&
                     ({1'b0, dist_sq} >= (SQ_W+1)'(RADIUS_SQ));

    assign cur_pix = mem_rdata_reg[{x_reg[2:0], 2'b00} +: PIX_W];

    always_comb
    begin
        new_pix = (func_reg == FUNC_INVERT) ? (PIX_W'(15) - cur_pix) : color_reg;
        new_word = mem_rdata_reg;
        new_word[{x_reg[2:0], 2'b00} +: PIX_W] = new_pix;
    end

    always_comb
    begin
        pbyte = '0;
        col   = '0;
        for (int k = 0; k < PIX_PER_WORD; k++)
        begin
            col = {1'b0, x_reg[X_W-1:3], 3'(k)};
            if (col < (X_W+1)'(SCREEN_WIDTH))
            begin
                pbyte[7-k] = mem_rdata_reg[{3'(k), plane_reg}];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg      <= func;
            x_reg         <= x;
            color_reg     <= color;
            plane_reg     <= plane;
            addr_reg      <= in_addr;
            on_screen_reg <= on_screen;
            blocked_reg   <= blocked;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            clr_addr_reg <= '0;
            acc_reg      <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            acc_reg      <= acc_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pixel_reg      <= pixel_next;
        plane_byte_reg <= plane_byte_next;
        changed_reg    <= changed_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:
            begin
                if (int'(clr_addr_reg) == STORE_WORDS - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (func == FUNC_CLEAR) ? ST_CLEAR : ST_RMW;
                end
            end
            ST_RMW:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR:
            begin
                if (int'(clr_addr_reg) == STORE_WORDS - 1)
                begin
                    state_next = ST_CLEAR_DONE;
                end
            end
            ST_CLEAR_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        mem_raddr       = in_addr;
        mem_waddr       = addr_reg;
        mem_wdata       = new_word;
        mem_we          = 1'b0;
        clr_addr_next   = clr_addr_reg;
        acc_next        = acc_reg;
        done_next       = 1'b0;
        pixel_next      = '0;
        plane_byte_next = '0;
        changed_next    = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                mem_raddr     = clr_addr_reg;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                mem_we        = 1'b1;
                clr_addr_next = (int'(clr_addr_reg) == STORE_WORDS - 1) ?
                                '0 : clr_addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                clr_addr_next = '0;
                acc_next      = 1'b0;
            end
            ST_RMW:
            begin
                done_next = 1'b1;
                if (on_screen_reg)
                begin
                    case (func_reg)
                        FUNC_WRITE, FUNC_INVERT:
                        begin
                            if (blocked_reg)
                            begin
                                pixel_next = cur_pix;
                            end
                            else
                            begin
                                mem_we       = 1'b1;
                                pixel_next   = new_pix;
                                changed_next = (new_pix != cur_pix);
                            end
                        end
                        FUNC_READ:
                        begin
                            pixel_next = cur_pix;
                        end
                        FUNC_PLANE:
                        begin
                            plane_byte_next = pbyte;
                        end
                        default:
                        begin
                            pixel_next = '0;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_raddr     = clr_addr_reg;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg != '0)
                begin
                    acc_next = acc_reg || (mem_rdata_reg != '0);
                end
            end
            ST_CLEAR_DONE:
            begin
                done_next    = 1'b1;
                changed_next = acc_reg || (mem_rdata_reg != '0);
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    assign done       = done_reg;
    assign pixel      = pixel_reg;
    assign plane_byte = plane_byte_reg;
    assign changed    = changed_reg;

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_RMW || $past(state_reg) == ST_CLEAR_DONE))
        else $error("Result strobe without a finished command.");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("Memory written while idle.");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("Accepted item did not make the block busy.");

    a_read_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && plane_byte_reg != '0) |-> !changed_reg)
        else $error("Plane read reported a change.");

    a_sweep_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR || state_reg == ST_INIT) |->
        (int'(clr_addr_reg) < STORE_WORDS))
        else $error("Sweep address beyond the store.");

endmodule

`default_nettype wire
